// ----- sv/text_console_cursor_engine_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the text console cursor engine
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TCCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TCCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg
// Types and constants shared by the cursor engine controller and datapath.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int CHAR_W  = 8;
  localparam int GLYPH_W = 7;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 6;

  localparam logic [CHAR_W-1:0]  CHR_LF        = 8'd10;
  localparam logic [CHAR_W-1:0]  CHR_CR        = 8'd13;
  localparam logic [CHAR_W-1:0]  CHR_CTRL_MAX  = 8'd31;
  localparam logic [CHAR_W-1:0]  CHR_DEL       = 8'd127;
  localparam logic [GLYPH_W-1:0] GLYPH_CURSOR  = 7'h5F;  // '_'

  typedef enum logic [1:0] {
    OP_ERASE  = 2'd0,
    OP_DRAW   = 2'd1,
    OP_SCROLL = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              first_of_string;
    logic              last_of_string;
  } in_item_t;

  typedef struct packed {
    op_t                op;
    logic [GLYPH_W-1:0] glyph;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    CLS_PRINT,
    CLS_NEWLINE,
    CLS_DELETE,
    CLS_BAD
  } char_cls_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADVANCE,
    CUR_NEWLINE,
    CUR_BACK,
    CUR_UPLINE,
    CUR_FETCH,
    CUR_SCROLL
  } cur_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERASE,
    S_BYTE,
    S_FETCH,
    S_DELERASE,
    S_SCROLL,
    S_CURSOR,
    S_HALT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    emit;
    op_t     op;
    logic    glyph_cursor;
    logic    last;
    cur_op_t cur;
  } dp_cmd_t;

  typedef struct packed {
    char_cls_t cls;
    logic      first;
    logic      lastb;
    logic      at_bottom;
    logic      at_right;
    logic      col_zero;
    logic      row_zero;
    logic      out_free;
  } dp_stat_t;

endpackage

// ----- sv/text_console_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Turns a stream of text bytes into cell drawing commands for a text grid.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one text byte per transaction, with string start/end flags.
//   out_* : zero to four drawing commands per byte; 'last' marks the final
//           command of a byte (a newline that does not scroll and has
//           neither string flag gives none).
// Sequencing: the sequencer issues at most one command per cycle; a delete
//   that steps back a line waits on the registered line-end store read, and
//   scrolling rotates the store base. in_ready rises right after the final
//   command is loaded when it is the cursor glyph; otherwise once the
//   sequencer has passed through the cursor state.
// Reset: cursor at (0,0), every line end reads zero, no clearing pass.
// Stall: with out_ready low the engine holds its command and waits; in_ready
//   stays low until the current byte is done. After an unsupported byte the
//   engine drops in_ready until reset.
// ----------------------------------------------------------------------------
module text_console_cursor_engine import tcce_pkg::*; #(
  parameter int COLS = 160,
  parameter int ROWS = 50
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcce_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- sv/tcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer: steps one byte through erase, action, scroll and cursor draw.
// ----------------------------------------------------------------------------
module tcce_ctrl import tcce_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    in_ready         = 1'b0;
    cmd.load         = 1'b0;
    cmd.emit         = 1'b0;
    cmd.op           = OP_ERASE;
    cmd.glyph_cursor = 1'b0;
    cmd.last         = 1'b0;
    cmd.cur          = CUR_HOLD;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ERASE;
        end
      end

      S_ERASE: begin
        if (!stat.first) begin
          state_nxt = S_BYTE;
        end else if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.op    = OP_ERASE;
          // only a newline that neither scrolls nor ends its string leaves nothing behind it
          cmd.last  = (stat.cls == CLS_NEWLINE) && !stat.at_bottom && !stat.lastb;
          state_nxt = S_BYTE;
        end
      end

      S_BYTE: begin
        unique case (stat.cls)
          CLS_PRINT: begin
            if (stat.out_free) begin
              cmd.emit  = 1'b1;
              cmd.op    = OP_DRAW;
              cmd.last  = !(stat.at_right && stat.at_bottom) && !stat.lastb;
              cmd.cur   = CUR_ADVANCE;
              state_nxt = (stat.at_right && stat.at_bottom) ? S_SCROLL : S_CURSOR;
            end
          end
          CLS_NEWLINE: begin
            cmd.cur   = CUR_NEWLINE;
            state_nxt = stat.at_bottom ? S_SCROLL : S_CURSOR;
          end
          CLS_DELETE: begin
            if (!stat.col_zero) begin
              cmd.cur   = CUR_BACK;
              state_nxt = S_DELERASE;
            end else if (!stat.row_zero) begin
              cmd.cur   = CUR_UPLINE;
              state_nxt = S_FETCH;
            end else begin
              state_nxt = S_DELERASE;
            end
          end
          CLS_BAD: begin
            if (stat.out_free) begin
              cmd.emit  = 1'b1;
              cmd.op    = OP_BAD;
              cmd.last  = 1'b1;
              state_nxt = S_HALT;
            end
          end
        endcase
      end

      S_FETCH: begin
        cmd.cur   = CUR_FETCH;
        state_nxt = S_DELERASE;
      end

      S_DELERASE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.op    = OP_ERASE;
          cmd.last  = !stat.lastb;
          state_nxt = S_CURSOR;
        end
      end

      S_SCROLL: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.op    = OP_SCROLL;
          cmd.last  = !stat.lastb;
          cmd.cur   = CUR_SCROLL;
          state_nxt = S_CURSOR;
        end
      end

      S_CURSOR: begin
        if (!stat.lastb) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit         = 1'b1;
          cmd.op           = OP_DRAW;
          cmd.glyph_cursor = 1'b1;
          cmd.last         = 1'b1;
          state_nxt        = S_IDLE;
        end
      end

      S_HALT: begin
        state_nxt = S_HALT;
      end
    endcase
  end

endmodule

// ----- sv/tcce_dp.sv -----
// ----------------------------------------------------------------------------
// tcce_dp
// Datapath: item register, cursor, line-end store and result register.
// ----------------------------------------------------------------------------
module tcce_dp import tcce_pkg::*; #(
  parameter int COLS = 160,
  parameter int ROWS = 50
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat
);

  localparam int RA_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [COL_W-1:0] COL_MAX  = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(ROWS - 1);
  localparam logic [RA_W:0]    ROWS_A   = (RA_W + 1)'(ROWS);
  localparam logic [RA_W-1:0]  BASE_MAX = RA_W'(ROWS - 1);

  in_item_t         item_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [RA_W-1:0]  base_r, base_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // line-end store, kept as a ring: logical row r lives at (base + r) mod ROWS
  logic [COL_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  mem_vld_r;
  logic [COL_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic             wr_en;
  logic [RA_W-1:0]  wr_addr;
  logic [COL_W-1:0] wr_data;
  logic [RA_W-1:0]  rd_addr;

  logic [RA_W-1:0]  row_idx, row_up_idx;
  logic [RA_W:0]    sum_cur, sum_up;
  logic [RA_W-1:0]  phys_cur, phys_up;
  logic [COL_W-1:0] rd_val;
  char_cls_t        cls;

  // classify the held byte
  always_comb begin
    if (item_r.char_code > CHR_CTRL_MAX && item_r.char_code < CHR_DEL) begin
      cls = CLS_PRINT;
    end else if (item_r.char_code == CHR_LF || item_r.char_code == CHR_CR) begin
      cls = CLS_NEWLINE;
    end else if (item_r.char_code == CHR_DEL) begin
      cls = CLS_DELETE;
    end else begin
      cls = CLS_BAD;
    end
  end

  always_comb begin
    row_idx    = row_r[RA_W-1:0];
    row_up_idx = (row_r == '0) ? '0 : row_idx - RA_W'(1);
    sum_cur    = {1'b0, base_r} + {1'b0, row_idx};
    sum_up     = {1'b0, base_r} + {1'b0, row_up_idx};
    phys_cur   = (sum_cur >= ROWS_A) ? RA_W'(sum_cur - ROWS_A) : sum_cur[RA_W-1:0];
    phys_up    = (sum_up >= ROWS_A) ? RA_W'(sum_up - ROWS_A) : sum_up[RA_W-1:0];
    rd_val     = rd_vld_r ? rd_data_r : '0;
  end

  always_comb begin
    stat.cls       = cls;
    stat.first     = item_r.first_of_string;
    stat.lastb     = item_r.last_of_string;
    stat.at_bottom = (row_r == ROW_MAX);
    stat.at_right  = (col_r == COL_MAX);
    stat.col_zero  = (col_r == '0);
    stat.row_zero  = (row_r == '0);
    stat.out_free  = !out_valid_r || out_ready;
  end

  // cursor and store update
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    wr_en    = 1'b0;
    wr_addr  = phys_cur;
    wr_data  = '0;
    rd_addr  = phys_up;
    case (cmd.cur)
      CUR_ADVANCE: begin
        wr_en   = 1'b1;
        wr_data = col_r;
        if (col_r == COL_MAX) begin
          col_nxt = '0;
          if (row_r != ROW_MAX) row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      CUR_NEWLINE: begin
        col_nxt = '0;
        if (row_r != ROW_MAX) row_nxt = row_r + ROW_W'(1);
      end
      CUR_BACK: begin
        col_nxt = col_r - COL_W'(1);
        wr_en   = 1'b1;
        wr_data = col_r - COL_W'(1);
      end
      CUR_UPLINE: begin
        wr_en   = 1'b1;
        row_nxt = row_r - ROW_W'(1);
      end
      CUR_FETCH: begin
        col_nxt = (rd_val > COL_MAX) ? COL_MAX : rd_val;
      end
      CUR_SCROLL: begin
        // old top row becomes the cleared bottom row
        wr_en    = 1'b1;
        wr_addr  = base_r;
        base_nxt = (base_r == BASE_MAX) ? '0 : base_r + RA_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) mem_vld_r[wr_addr] <= 1'b1;
      rd_vld_r <= mem_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.op   <= cmd.op;
      out_data_r.last <= cmd.last;
      if (cmd.op == OP_DRAW) begin
        out_data_r.glyph <= cmd.glyph_cursor ? GLYPH_CURSOR
                                             : item_r.char_code[GLYPH_W-1:0];
      end else begin
        out_data_r.glyph <= '0;
      end
      if (cmd.op == OP_SCROLL) begin
        out_data_r.cell_col <= '0;
        out_data_r.cell_row <= ROW_MAX;
      end else begin
        out_data_r.cell_col <= col_r;
        out_data_r.cell_row <= row_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/tcce_checker.sv -----
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks for the text console cursor engine, bound to the top.
// ----------------------------------------------------------------------------
`include "text_console_cursor_engine_assert.svh"

module tcce_checker import tcce_pkg::*; #(
  parameter int COLS = 160,
  parameter int ROWS = 50
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic in_stall;
  logic out_stall;
  logic out_take;
  logic out_bad;
  logic on_grid;

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_take  = out_valid && out_ready;
  assign out_bad   = out_valid && (out_data.op == OP_BAD);
  assign on_grid   = (out_data.cell_col < COLS) && (out_data.cell_row < ROWS);

  // a waiting input transaction must hold
  `TCCE_ASSERT_NXT(a_in_hold, in_stall, in_valid && $stable(in_data), "input changed while waiting")

  // a stalled command must hold
  `TCCE_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled command changed")

  // an unsupported-byte report ends its byte
  `TCCE_ASSERT_IMP(a_bad_last, out_bad, out_data.last, "bad report without last")

  // once the unsupported byte is reported the engine takes nothing more
  `TCCE_ASSERT_NXT(a_halt, out_take && out_data.op == OP_BAD, !in_ready, "input taken after halt")

  // every command lands on the grid
  `TCCE_ASSERT_IMP(a_in_grid, out_valid, on_grid, "cell outside grid")

endmodule

bind text_console_cursor_engine tcce_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_checker (.*);
